// ----- hdl/mrrc_pkg.sv -----
// Shared types, constants and the CRC16 step of the Modbus RTU response checker.
package mrrc_pkg;

  localparam int MAX_FRAME_BYTES = 256;
  localparam int MAX_REGISTERS   = 125;
  localparam int POS_W           = 9;
  localparam int FIFO_DEPTH      = 2;

  // transaction modes
  localparam logic [1:0] MODE_RD_HOLD  = 2'd0;
  localparam logic [1:0] MODE_RD_INPUT = 2'd1;
  localparam logic [1:0] MODE_WR_SINGLE = 2'd2;

  // function codes
  localparam logic [7:0] FUNC_RD_HOLD   = 8'h03;
  localparam logic [7:0] FUNC_RD_INPUT  = 8'h04;
  localparam logic [7:0] FUNC_WR_SINGLE = 8'h06;
  localparam logic [7:0] FUNC_EXC_BIT   = 8'h80;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // configuration register indexes
  localparam logic [2:0] CFG_MODE     = 3'd0;
  localparam logic [2:0] CFG_SLAVE    = 3'd1;
  localparam logic [2:0] CFG_REG_ADDR = 3'd2;
  localparam logic [2:0] CFG_REG_CNT  = 3'd3;
  localparam logic [2:0] CFG_WR_VAL   = 3'd4;

  // frame status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_CRC       = 3'd2;
  localparam logic [2:0] ST_EXCEPTION = 3'd3;
  localparam logic [2:0] ST_MISMATCH  = 3'd4;
  localparam logic [2:0] ST_BAD_COUNT = 3'd5;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  slave_address;
    logic [15:0] register_address;
    logic [6:0]  register_count;
    logic [15:0] write_value;
  } cfg_t;

  // one classified byte between front and back
  typedef struct packed {
    logic [7:0]       rx_byte;
    logic             frame_end;
    logic             keep;
    logic [POS_W-1:0] pos;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [6:0]  word_index;
    logic [15:0] word_value;
    logic [2:0]  frame_status;
    logic [7:0]  exception_code;
    logic        last;
  } result_t;

  function automatic logic is_read(input logic [1:0] mode);
    is_read = (mode == MODE_RD_HOLD) || (mode == MODE_RD_INPUT);
  endfunction

  // reflected CRC16 over one byte, bitwise
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    crc_fold = c;
  endfunction

endpackage

// ----- hdl/mrrc_fifo.sv -----
// Two-entry queue of classified bytes between front and back.
module mrrc_fifo
  import mrrc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t pop_item_o
);

  item_t      mem_q [FIFO_DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = (count_q == 2'(FIFO_DEPTH));
  assign valid_o    = (count_q != 2'd0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- hdl/mrrc_front.sv -----
// Front end: accepts bytes, tracks frame position and applies the receive cap.
module mrrc_front
  import mrrc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_end_i,
  input  logic       fifo_full_i,
  output logic       push_o,
  output item_t      push_item_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [9:0]       cap_raw;
  logic [9:0]       cap;
  logic             keep;

  always_comb begin
    cap_raw = 10'd15 + {2'b00, cfg_i.register_count, 1'b0};
    if (!is_read(cfg_i.mode)) begin
      cap = 10'd12;
    end else if (cap_raw > 10'(MAX_FRAME_BYTES)) begin
      cap = 10'(MAX_FRAME_BYTES);
    end else begin
      cap = cap_raw;
    end
    keep = ({1'b0, pos_q} < cap);
  end

  assign in_ready_o = ~fifo_full_i;
  assign push_o     = in_valid_i & ~fifo_full_i;

  always_comb begin
    push_item_o.rx_byte   = in_byte_i;
    push_item_o.frame_end = in_end_i;
    push_item_o.keep      = keep;
    push_item_o.pos       = pos_q;
  end

  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      if (in_end_i)  pos_d = '0;
      else if (keep) pos_d = pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ----- hdl/mrrc_back.sv -----
// Back end: CRC, header and echo checks, word assembly and the output register.
module mrrc_back
  import mrrc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  logic [15:0] crc_q, crc_d, crc_n;
  logic [7:0]  prev_q, prev_d, prev_n;
  logic [7:0]  bbp_q, bbp_d, bbp_n;
  logic [7:0]  addr_q, addr_d, addr_n;
  logic [7:0]  func_q, func_d, func_n;
  logic [7:0]  third_q, third_d, third_n;
  logic        echo_q, echo_d, echo_n;
  logic        out_valid_q, out_valid_d;
  result_t     out_q, out_d;

  logic [7:0]       b;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] total;
  logic [POS_W-1:0] widx;
  logic [7:0]       echo_exp;
  logic [7:0]       func_exp;
  logic             word_ok;
  logic [2:0]       status;
  logic [7:0]       exc;

  assign b   = item_i.rx_byte;
  assign pos = item_i.pos;

  assign pop_o = item_valid_i & (~out_valid_q | out_ready_i);

  always_comb begin
    case (pos[2:0])
      3'd0:    echo_exp = cfg_i.slave_address;
      3'd1:    echo_exp = FUNC_WR_SINGLE;
      3'd2:    echo_exp = cfg_i.register_address[15:8];
      3'd3:    echo_exp = cfg_i.register_address[7:0];
      3'd4:    echo_exp = cfg_i.write_value[15:8];
      default: echo_exp = cfg_i.write_value[7:0];
    endcase
    case (cfg_i.mode)
      MODE_RD_HOLD:  func_exp = FUNC_RD_HOLD;
      MODE_RD_INPUT: func_exp = FUNC_RD_INPUT;
      default:       func_exp = FUNC_WR_SINGLE;
    endcase
  end

  // frame state after this byte
  always_comb begin
    crc_n   = crc_q;
    prev_n  = prev_q;
    bbp_n   = bbp_q;
    addr_n  = addr_q;
    func_n  = func_q;
    third_n = third_q;
    echo_n  = echo_q;
    if (item_i.keep) begin
      if (pos >= POS_W'(2)) crc_n = crc_fold(crc_q, bbp_q);
      if (pos == POS_W'(0)) addr_n  = b;
      if (pos == POS_W'(1)) func_n  = b;
      if (pos == POS_W'(2)) third_n = b;
      if (pos < POS_W'(6) && b != echo_exp) echo_n = 1'b1;
      bbp_n  = prev_q;
      prev_n = b;
    end
    total = item_i.keep ? pos + POS_W'(1) : pos;
    widx  = (pos - POS_W'(4)) >> 1;
    word_ok = item_i.keep && is_read(cfg_i.mode) && (pos >= POS_W'(4)) && !pos[0]
              && (widx < {2'b00, cfg_i.register_count}) && (widx < POS_W'(MAX_REGISTERS));
  end

  // final status, checks in priority order
  always_comb begin
    status = ST_OK;
    exc    = 8'h00;
    if (total < POS_W'(5)) begin
      status = ST_SHORT;
    end else if (crc_n != {prev_n, bbp_n}) begin
      status = ST_CRC;
    end else if ((func_n & FUNC_EXC_BIT) != 8'h00) begin
      status = ST_EXCEPTION;
      exc    = third_n;
    end else if (addr_n != cfg_i.slave_address || func_n != func_exp) begin
      status = ST_MISMATCH;
    end else if (is_read(cfg_i.mode)) begin
      if (third_n != {cfg_i.register_count, 1'b0}) status = ST_BAD_COUNT;
    end else if (echo_n || total < POS_W'(6)) begin
      status = ST_MISMATCH;
    end
  end

  always_comb begin
    crc_d       = crc_q;
    prev_d      = prev_q;
    bbp_d       = bbp_q;
    addr_d      = addr_q;
    func_d      = func_q;
    third_d     = third_q;
    echo_d      = echo_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (pop_o) begin
      if (item_i.frame_end) begin
        crc_d   = CRC_INIT;
        prev_d  = 8'h00;
        bbp_d   = 8'h00;
        addr_d  = 8'h00;
        func_d  = 8'h00;
        third_d = 8'h00;
        echo_d  = 1'b0;
        out_valid_d          = 1'b1;
        out_d.result_kind    = 1'b1;
        out_d.word_index     = 7'd0;
        out_d.word_value     = 16'h0000;
        out_d.frame_status   = status;
        out_d.exception_code = exc;
        out_d.last           = 1'b1;
      end else begin
        crc_d   = crc_n;
        prev_d  = prev_n;
        bbp_d   = bbp_n;
        addr_d  = addr_n;
        func_d  = func_n;
        third_d = third_n;
        echo_d  = echo_n;
        if (word_ok) begin
          out_valid_d          = 1'b1;
          out_d.result_kind    = 1'b0;
          out_d.word_index     = widx[6:0];
          out_d.word_value     = {prev_q, b};
          out_d.frame_status   = ST_OK;
          out_d.exception_code = 8'h00;
          out_d.last           = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CRC_INIT;
      prev_q      <= 8'h00;
      bbp_q       <= 8'h00;
      addr_q      <= 8'h00;
      func_q      <= 8'h00;
      third_q     <= 8'h00;
      echo_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      prev_q      <= prev_d;
      bbp_q       <= bbp_d;
      addr_q      <= addr_d;
      func_q      <= func_d;
      third_q     <= third_d;
      echo_q      <= echo_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ----- hdl/modbus_rtu_response_checker.sv -----
// Modbus RTU response checker top level: config registers, front, queue and back.
//
// Usage:
//   s_axis: one response byte per beat in tdata; tlast marks the closing byte.
//   m_axis: one result beat per word or frame. tuser = 0 is a provisional
//     register word (discard unless the frame status is OK); tuser = 1 is the
//     final status and carries tlast. tdata fields from bit 0: word_index(7),
//     word_value(16), frame_status(3), exception_code(8), zero pad to 40 bits.
//   cfg: cfg_index_i selects mode, slave address, register address, register
//     count or write value; always ready. Write only while the block is idle.
// Throughput: one byte per cycle, sustained while m_axis_tready is high. An
//   accepted beat passes the queue stage, then the output register, before its
//   result shows on m_axis. The per-byte CRC16 step is a combinational bitwise fold.
// A two-beat queue parts the front (position and receive cap) from the back
//   (CRC, checks, output), so a stalled m_axis keeps s_axis open for up to two more
//   bytes before s_axis_tready drops.
// Reset clears the frame state, the queue and the output, and loads the
//   register defaults: read holding, slave 1, address 0, count 1, value 0.
module modbus_rtu_response_checker
  import mrrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // byte input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  input  logic        s_axis_tlast,   // frame_end
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // word_index, word_value, frame_status,
                                      // exception_code, zero pad
  output logic        m_axis_tuser,   // result_kind
  output logic        m_axis_tlast    // last
);

  cfg_t    cfg_q, cfg_d;
  logic    fifo_full;
  logic    push;
  item_t   push_item;
  logic    pop;
  logic    fifo_valid;
  item_t   pop_item;
  result_t res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MODE:     cfg_d.mode             = cfg_data_i[1:0];
        CFG_SLAVE:    cfg_d.slave_address    = cfg_data_i[7:0];
        CFG_REG_ADDR: cfg_d.register_address = cfg_data_i;
        CFG_REG_CNT:  cfg_d.register_count   = cfg_data_i[6:0];
        CFG_WR_VAL:   cfg_d.write_value      = cfg_data_i;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode             <= MODE_RD_HOLD;
      cfg_q.slave_address    <= 8'd1;
      cfg_q.register_address <= 16'd0;
      cfg_q.register_count   <= 7'd1;
      cfg_q.write_value      <= 16'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mrrc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_end_i    (s_axis_tlast),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  mrrc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .valid_o     (fifo_valid),
    .pop_item_o  (pop_item)
  );

  mrrc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (fifo_valid),
    .item_i       (pop_item),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (res)
  );

  assign m_axis_tdata = {6'd0, res.exception_code, res.frame_status,
                         res.word_value, res.word_index};
  assign m_axis_tuser = res.result_kind;
  assign m_axis_tlast = res.last;

endmodule
